// ===== sv/mrcp_pkg.sv =====
// ----------------------------------------------------------------------------
// mrcp_pkg
// shared types and constants of the midi remote command parser
// ----------------------------------------------------------------------------
package mrcp_pkg;

  localparam int CTRL_COUNT = 128;
  localparam int CTRL_W     = $clog2(CTRL_COUNT);
  localparam int VAL_W      = 7;

  // result kinds
  typedef enum logic [2:0] {
    KIND_NOTE_ON  = 3'd0,
    KIND_NOTE_OFF = 3'd1,
    KIND_CC       = 3'd2,
    KIND_PROG     = 3'd3,
    KIND_ECHO     = 3'd4
  } kind_e;

  // configuration register indexes
  localparam logic [1:0] CFG_LISTEN_CHANNEL = 2'd0;
  localparam logic [1:0] CFG_BYPASS_MODE    = 2'd1;
  localparam logic [1:0] CFG_CC_BOUND_LOW   = 2'd2;
  localparam logic [1:0] CFG_CC_BOUND_HIGH  = 2'd3;

  // status bytes
  localparam logic [7:0] ST_SYSEX     = 8'hF0;
  localparam logic [7:0] ST_SONG_POS  = 8'hF2;
  localparam logic [7:0] ST_SONG_SEL  = 8'hF3;
  localparam logic [7:0] ST_NOTE_OFF  = 8'h80;
  localparam logic [7:0] ST_NOTE_ON   = 8'h90;
  localparam logic [7:0] ST_CTRL_CHG  = 8'hB0;
  localparam logic [7:0] ST_PROG_CHG  = 8'hC0;
  localparam logic [3:0] ST_SYSTEM_HI = 4'hF;

  // command code prefixes
  localparam logic [15:0] CODE_NOTE_ON  = 16'h9000;
  localparam logic [15:0] CODE_NOTE_OFF = 16'hA000;
  localparam logic [15:0] CODE_CTRL_CHG = 16'hB000;
  localparam logic [15:0] CODE_PROG_CHG = 16'hC000;

  localparam logic [2:0] POS_MAX = 3'd5;
  localparam logic [2:0] POS_TWO = 3'd2;

  // one classified item travelling from front to back
  typedef struct packed {
    kind_e             kind;
    logic [15:0]       code;
    logic [CTRL_W-1:0] ctrl;
    logic [7:0]        echo;
    logic              is_cc;
  } op_t;

endpackage

// ===== sv/midi_remote_command_parser_top.sv =====
// an accepted byte's result passes through the queue, the back stage register and the output register
// throughput: one byte per cycle while the output drains, limited by the single back stage and its table port
// a stalled output holds one result while up to two more ops wait in the queue
// reset clears parser state, configuration and the controller seen flags at once;
// the controller value memory itself is not swept, the value of an unseen entry is ignored when read
// ----------------------------------------------------------------------------
// midi_remote_command_parser_top
// midi running status parser (or raw byte echo in bypass mode) turning channel messages into command codes
// ----------------------------------------------------------------------------
module midi_remote_command_parser_top import mrcp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  // byte input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  midi_byte_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  result_kind_o,
  output logic [15:0] command_code_o,
  output logic [6:0]  controller_index_o,
  output logic [7:0]  echo_byte_o
);

  // configuration registers
  logic [3:0]  listen_channel_q;
  logic        bypass_mode_q;
  logic [63:0] cc_bound_low_q;
  logic [63:0] cc_bound_high_q;

  logic in_accept;
  logic push;
  op_t  push_op;
  logic q_full;
  logic q_valid;
  op_t  q_head;
  logic q_pop;
  op_t  out_op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      listen_channel_q <= '0;
      bypass_mode_q    <= 1'b0;
      cc_bound_low_q   <= '0;
      cc_bound_high_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_LISTEN_CHANNEL: listen_channel_q <= cfg_data_i[3:0];
        CFG_BYPASS_MODE:    bypass_mode_q    <= cfg_data_i[0];
        CFG_CC_BOUND_LOW:   cc_bound_low_q   <= cfg_data_i;
        CFG_CC_BOUND_HIGH:  cc_bound_high_q  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // the front only needs queue space, never the output side
  assign in_ready_o = !q_full;
  assign in_accept  = in_valid_i && in_ready_o;

  // front: running status and classification of each byte
  mrcp_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (in_accept),
    .midi_byte_i     (midi_byte_i),
    .listen_channel_i(listen_channel_q),
    .bypass_mode_i   (bypass_mode_q),
    .push_o          (push),
    .op_o            (push_op)
  );

  // short queue decoupling front and back
  mrcp_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .push_op_i(push_op),
    .pop_i    (q_pop),
    .full_o   (q_full),
    .valid_o  (q_valid),
    .head_o   (q_head)
  );

  // back: controller table read-modify-write and result transfer
  mrcp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_head_i   (q_head),
    .q_pop_o    (q_pop),
    .cc_bound_i ({cc_bound_high_q, cc_bound_low_q}),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_op_o   (out_op)
  );

  assign result_kind_o      = out_op.kind;
  assign command_code_o     = out_op.code;
  assign controller_index_o = out_op.ctrl;
  assign echo_byte_o        = out_op.echo;

endmodule

// ===== sv/mrcp_front.sv =====
// ----------------------------------------------------------------------------
// mrcp_front
// running status tracker, classifies each byte into an op for the back end
// ----------------------------------------------------------------------------
module mrcp_front import mrcp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] midi_byte_i,
  input  logic [3:0] listen_channel_i,
  input  logic       bypass_mode_i,
  output logic       push_o,
  output op_t        op_o
);

  logic [7:0]       act_q, act_d;
  logic [7:0]       rcc_q, rcc_d;
  logic [3:0]       chan_q, chan_d;
  logic [2:0]       pos_q, pos_d;
  logic [VAL_W-1:0] first_q, first_d;
  logic [VAL_W-1:0] second_q, second_d;
  logic             produce;
  logic             match;

  assign match = (chan_q == listen_channel_i);

  always_comb begin
    act_d    = act_q;
    rcc_d    = rcc_q;
    chan_d   = chan_q;
    pos_d    = pos_q;
    first_d  = first_q;
    second_d = second_q;
    produce  = 1'b0;
    op_o     = '0;
    op_o.kind = KIND_NOTE_ON;
    if (bypass_mode_i) begin
      produce   = 1'b1;
      op_o.kind = KIND_ECHO;
      op_o.echo = midi_byte_i;
    end else if (midi_byte_i[7:4] == ST_SYSTEM_HI) begin
      if (midi_byte_i == ST_SYSEX || midi_byte_i == ST_SONG_POS ||
          midi_byte_i == ST_SONG_SEL) begin
        act_d = midi_byte_i;
      end else begin
        act_d = rcc_q;
      end
      pos_d = '0;
    end else if (midi_byte_i[7]) begin
      act_d  = {midi_byte_i[7:4], 4'h0};
      rcc_d  = {midi_byte_i[7:4], 4'h0};
      chan_d = midi_byte_i[3:0];
      pos_d  = '0;
    end else begin
      if (pos_q == 3'd0) first_d = midi_byte_i[VAL_W-1:0];
      if (pos_q == 3'd1) second_d = midi_byte_i[VAL_W-1:0];
      pos_d = (pos_q < POS_MAX) ? pos_q + 3'd1 : pos_q;
      unique case (act_q)
        ST_SONG_POS: begin
          if (pos_d >= POS_TWO) begin
            act_d = rcc_q;
            pos_d = '0;
          end
        end
        ST_SONG_SEL: begin
          act_d = rcc_q;
          pos_d = '0;
        end
        ST_NOTE_OFF: begin
          if (pos_d >= POS_TWO) begin
            pos_d = '0;
            if (match) begin
              produce   = 1'b1;
              op_o.kind = KIND_NOTE_OFF;
              op_o.code = CODE_NOTE_OFF | {9'd0, first_d};
            end
          end
        end
        ST_NOTE_ON: begin
          if (pos_d >= POS_TWO) begin
            pos_d = '0;
            if (match) begin
              produce = 1'b1;
              // velocity zero means note off
              if (second_d == '0) begin
                op_o.kind = KIND_NOTE_OFF;
                op_o.code = CODE_NOTE_OFF | {9'd0, first_d};
              end else begin
                op_o.kind = KIND_NOTE_ON;
                op_o.code = CODE_NOTE_ON | {9'd0, first_d};
              end
            end
          end
        end
        ST_CTRL_CHG: begin
          if (pos_d >= POS_TWO) begin
            pos_d = '0;
            if (match) begin
              produce    = 1'b1;
              op_o.kind  = KIND_CC;
              op_o.is_cc = 1'b1;
              op_o.code  = CODE_CTRL_CHG | {9'd0, second_d};
              op_o.ctrl  = first_d;
            end
          end
        end
        ST_PROG_CHG: begin
          pos_d = '0;
          if (match) begin
            produce   = 1'b1;
            op_o.kind = KIND_PROG;
            op_o.code = CODE_PROG_CHG | {9'd0, first_d};
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign push_o = accept_i && produce;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q    <= '0;
      rcc_q    <= '0;
      chan_q   <= '0;
      pos_q    <= '0;
      first_q  <= '0;
      second_q <= '0;
    end else if (accept_i) begin
      act_q    <= act_d;
      rcc_q    <= rcc_d;
      chan_q   <= chan_d;
      pos_q    <= pos_d;
      first_q  <= first_d;
      second_q <= second_d;
    end
  end

endmodule

// ===== sv/mrcp_queue.sv =====
// ----------------------------------------------------------------------------
// mrcp_queue
// two-entry op queue between front and back
// ----------------------------------------------------------------------------
module mrcp_queue import mrcp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  push_op_i,
  input  logic pop_i,
  output logic full_o,
  output logic valid_o,
  output op_t  head_o
);

  localparam int Depth = 2;
  localparam int AW    = $clog2(Depth);

  op_t           mem_q [Depth];
  logic [AW-1:0] wptr_q, rptr_q;
  logic [AW:0]   cnt_q;

  assign full_o  = (cnt_q == (AW+1)'(Depth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= push_op_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= (wptr_q == AW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
      if (pop_i)  rptr_q <= (rptr_q == AW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== sv/mrcp_ram.sv =====
// ----------------------------------------------------------------------------
// mrcp_ram
// generic single write, single read ram with registered read
// ----------------------------------------------------------------------------
module mrcp_ram #(
  parameter int Width = 8,
  parameter int Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  assign rdata_o = rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

endmodule

// ===== sv/mrcp_back.sv =====
// ----------------------------------------------------------------------------
// mrcp_back
// executes ops: controller table check and update, output register
// ----------------------------------------------------------------------------
module mrcp_back import mrcp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  op_t                   q_head_i,
  output logic                  q_pop_o,
  input  logic [CTRL_COUNT-1:0] cc_bound_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output op_t                   out_op_o
);

  op_t               s1_op_q;
  logic              s1_valid_q;
  logic              fwd_q;
  logic [VAL_W-1:0]  fwd_data_q;
  logic [CTRL_COUNT-1:0] seen_q;
  logic              out_valid_q;
  op_t               out_op_q;

  logic              out_free;
  logic              s1_emit;
  logic              s1_go;
  logic              report;
  logic              old_seen;
  logic [VAL_W-1:0]  old_val;
  logic [VAL_W-1:0]  rdata;
  logic              we;

  mrcp_ram #(
    .Width(VAL_W),
    .Depth(CTRL_COUNT)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(s1_op_q.ctrl),
    .wdata_i(s1_op_q.code[VAL_W-1:0]),
    .re_i   (q_pop_o),
    .raddr_i(q_head_i.ctrl),
    .rdata_o(rdata)
  );

  // a write in the same cycle as the read is forwarded
  assign old_seen = seen_q[s1_op_q.ctrl] || fwd_q;
  assign old_val  = fwd_q ? fwd_data_q : rdata;
  assign report   = (old_seen && (old_val != s1_op_q.code[VAL_W-1:0])) ||
                    cc_bound_i[s1_op_q.ctrl];

  assign out_free = !out_valid_q || out_ready_i;
  assign s1_emit  = !s1_op_q.is_cc || report;
  assign s1_go    = s1_valid_q && (!s1_emit || out_free);
  assign q_pop_o  = q_valid_i && (!s1_valid_q || s1_go);
  assign we       = s1_go && s1_op_q.is_cc;

  assign out_valid_o = out_valid_q;
  assign out_op_o    = out_op_q;

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      s1_op_q    <= q_head_i;
      fwd_data_q <= s1_op_q.code[VAL_W-1:0];
    end
    if (s1_go && s1_emit) out_op_q <= s1_op_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_q       <= 1'b0;
      seen_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        s1_valid_q <= 1'b1;
        fwd_q      <= we && (s1_op_q.ctrl == q_head_i.ctrl);
      end else if (s1_go) begin
        s1_valid_q <= 1'b0;
      end
      if (we) seen_q[s1_op_q.ctrl] <= 1'b1;
      if (s1_go && s1_emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// ===== sim/midi_remote_command_parser_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_remote_command_parser_top_test
// drives midi byte streams into the parser and checks every command it emits
// against a cycle-free model of the running status parser kept in this bench;
// a short table of hand-picked bytes comes first, then phases of random
// messages under changing listen channel, bypass and bound-controller settings
// ----------------------------------------------------------------------------
module midi_remote_command_parser_top_test;
  import mrcp_pkg::*;

  localparam int          PHASES        = 6;
  localparam int          PHASE_ITEMS   = 200;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          HOLD_CYCLES   = 300;
  localparam int unsigned CYCLE_LIMIT   = 400000;

  // bytes the package does not name
  localparam logic [7:0] RT_CLOCK      = 8'hF8;
  localparam logic [7:0] SYSEX_END     = 8'hF7;
  localparam logic [7:0] ST_CHAN_PRESS = 8'hD0;
  localparam logic [7:0] CV_UNSEEN     = 8'h80;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] code;
    logic [6:0]  ctrl;
    logic [7:0]  echo;
  } cmd_result_t;

  // one row of the directed table; typed rows carry their command inline
  typedef struct packed {
    logic [7:0]  midi;
    logic        typed;
    logic        has_res;
    kind_e       kind;
    logic [15:0] code;
  } dir_row_t;

  localparam int DIR_COUNT = 26;
  localparam dir_row_t DIR_ROWS [DIR_COUNT] = '{
    // data byte before any status: ignored
    '{8'h00,                 1'b1, 1'b0, KIND_NOTE_ON,  16'h0000},
    '{ST_NOTE_ON,            1'b0, 1'b0, KIND_NOTE_ON,  16'h0000},
    '{8'h3C,                 1'b0, 1'b0, KIND_NOTE_ON,  16'h0000},
    '{8'h7F,                 1'b1, 1'b1, KIND_NOTE_ON,  CODE_NOTE_ON | 16'h3C},
    // running status, velocity zero turns into a note off
    '{8'h00,                 1'b0, 1'b0, KIND_NOTE_ON,  16'h0000},
    '{8'h00,                 1'b1, 1'b1, KIND_NOTE_OFF, CODE_NOTE_OFF | 16'h00},
    '{ST_NOTE_OFF,           1'b0, 1'b0, KIND_NOTE_ON,  16'h0000},
    '{8'h7F,                 1'b0, 1'b0, KIND_NOTE_ON,  16'h0000},
    '{8'h7F,                 1'b1, 1'b1, KIND_NOTE_OFF, CODE_NOTE_OFF | 16'h7F},
    // controller 7: first value only stored, a changed value reports
    '{ST_CTRL_CHG,           1'b0, 1'b0, KIND_NOTE_ON,  16'h0000},
    '{8'h07,                 1'b0, 1'b0, KIND_NOTE_ON,  16'h0000},
    '{8'h10,                 1'b0, 1'b0, KIND_NOTE_ON,  16'h0000},
    '{8'h07,                 1'b0, 1'b0, KIND_NOTE_ON,  16'h0000},
    '{8'h7F,                 1'b0, 1'b0, KIND_NOTE_ON,  16'h0000},
    // song select swallows its byte
    '{ST_SONG_SEL,           1'b0, 1'b0, KIND_NOTE_ON,  16'h0000},
    '{8'h01,                 1'b0, 1'b0, KIND_NOTE_ON,  16'h0000},
    '{ST_PROG_CHG,           1'b0, 1'b0, KIND_NOTE_ON,  16'h0000},
    '{8'h05,                 1'b1, 1'b1, KIND_PROG,     CODE_PROG_CHG | 16'h05},
    // song position swallows two bytes
    '{ST_SONG_POS,           1'b0, 1'b0, KIND_NOTE_ON,  16'h0000},
    '{8'h10,                 1'b0, 1'b0, KIND_NOTE_ON,  16'h0000},
    '{8'h20,                 1'b0, 1'b0, KIND_NOTE_ON,  16'h0000},
    // note on another channel, broken up by a clock tick
    '{ST_NOTE_ON | 8'h0F,    1'b0, 1'b0, KIND_NOTE_ON,  16'h0000},
    '{8'h7F,                 1'b0, 1'b0, KIND_NOTE_ON,  16'h0000},
    '{RT_CLOCK,              1'b0, 1'b0, KIND_NOTE_ON,  16'h0000},
    '{8'h40,                 1'b0, 1'b0, KIND_NOTE_ON,  16'h0000},
    '{8'h00,                 1'b0, 1'b0, KIND_NOTE_ON,  16'h0000}
  };

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [1:0]  cfg_index_i = CFG_LISTEN_CHANNEL;
  logic [63:0] cfg_data_i  = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [7:0]  midi_byte_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  result_kind_o;
  logic [15:0] command_code_o;
  logic [6:0]  controller_index_o;
  logic [7:0]  echo_byte_o;

  // travels with the payload so the monitor sees the matching row
  logic        row_typed   = 1'b0;
  logic        row_has_res = 1'b0;
  cmd_result_t row_want    = '{KIND_NOTE_ON, 16'h0000, 7'h00, 8'h00};

  // pacing controls shared by sender and receiver
  logic        steady        = 1'b0;
  int          holdoff_asked = 0;

  int          mismatches  = 0;
  int unsigned cycle_count = 0;

  cmd_result_t pending_cmds [$];
  logic [7:0]  byte_burst [$];

  // parser state and configuration as seen by the bench
  logic [3:0]   cf_channel = 4'h0;
  logic         cf_bypass  = 1'b0;
  logic [127:0] cf_bound   = '0;
  logic [7:0]   ps_active      = 8'h00;
  logic [7:0]   ps_running_cmd = 8'h00;
  logic [3:0]   ps_running_ch  = 4'h0;
  logic [2:0]   ps_pos         = 3'd0;
  logic [6:0]   ps_first       = 7'h00;
  logic [6:0]   ps_second      = 7'h00;
  logic [7:0]   ps_ctrl_val [CTRL_COUNT] = '{default: CV_UNSEEN};

  midi_remote_command_parser_top u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .midi_byte_i        (midi_byte_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .result_kind_o      (result_kind_o),
    .command_code_o     (command_code_o),
    .controller_index_o (controller_index_o),
    .echo_byte_o        (echo_byte_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // advance the parser by one byte, return the command it produces if any
  task automatic parse_midi_byte(input logic [7:0] b, output bit hit,
                                 output cmd_result_t r);
    logic       chan_match;
    logic [6:0] cn;
    logic [7:0] old;
    logic       report;
    hit    = 1'b0;
    r.kind = KIND_NOTE_ON;
    r.code = '0;
    r.ctrl = '0;
    r.echo = '0;
    if (cf_bypass) begin
      hit    = 1'b1;
      r.kind = KIND_ECHO;
      r.echo = b;
    end else if (b[7:4] == ST_SYSTEM_HI) begin
      // any system byte, real-time too, restarts the data count
      if (b == ST_SYSEX || b == ST_SONG_POS || b == ST_SONG_SEL)
        ps_active = b;
      else
        ps_active = ps_running_cmd;
      ps_pos = 3'd0;
    end else if (b[7]) begin
      ps_active      = {b[7:4], 4'h0};
      ps_running_cmd = ps_active;
      ps_running_ch  = b[3:0];
      ps_pos         = 3'd0;
    end else begin
      if (ps_pos == 3'd0)
        ps_first = b[6:0];
      else if (ps_pos == 3'd1)
        ps_second = b[6:0];
      if (ps_pos < POS_MAX)
        ps_pos = ps_pos + 3'd1;
      chan_match = (ps_running_ch == cf_channel);
      case (ps_active)
        ST_SONG_POS: begin
          if (ps_pos >= POS_TWO) begin
            ps_active = ps_running_cmd;
            ps_pos    = 3'd0;
          end
        end
        ST_SONG_SEL: begin
          ps_active = ps_running_cmd;
          ps_pos    = 3'd0;
        end
        ST_NOTE_OFF, ST_NOTE_ON: begin
          if (ps_pos >= POS_TWO) begin
            ps_pos = 3'd0;
            if (chan_match) begin
              hit = 1'b1;
              if (ps_active == ST_NOTE_ON && ps_second != 7'h00) begin
                r.kind = KIND_NOTE_ON;
                r.code = CODE_NOTE_ON | 16'(ps_first);
              end else begin
                r.kind = KIND_NOTE_OFF;
                r.code = CODE_NOTE_OFF | 16'(ps_first);
              end
            end
          end
        end
        ST_CTRL_CHG: begin
          if (ps_pos >= POS_TWO) begin
            ps_pos = 3'd0;
            if (chan_match) begin
              cn     = ps_first;
              old    = ps_ctrl_val[cn];
              report = (!old[7] && old[6:0] != ps_second) || cf_bound[cn];
              ps_ctrl_val[cn] = {1'b0, ps_second};
              if (report) begin
                hit    = 1'b1;
                r.kind = KIND_CC;
                r.code = CODE_CTRL_CHG | 16'(ps_second);
                r.ctrl = cn;
              end
            end
          end
        end
        ST_PROG_CHG: begin
          ps_pos = 3'd0;
          if (chan_match) begin
            hit    = 1'b1;
            r.kind = KIND_PROG;
            r.code = CODE_PROG_CHG | 16'(ps_first);
          end
        end
        default: begin
          // other commands only move the data count
        end
      endcase
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    case (idx)
      CFG_LISTEN_CHANNEL: cf_channel      = val[3:0];
      CFG_BYPASS_MODE:    cf_bypass       = val[0];
      CFG_CC_BOUND_LOW:   cf_bound[63:0]  = val;
      default:            cf_bound[127:64] = val;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // offer one byte; valid is only lowered while idling so it never toggles in one step
  task automatic send_byte(input logic [7:0] b, input logic typed, input logic has_res,
                           input cmd_result_t want);
    while (!steady && $urandom_range(99) < 34) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    midi_byte_i <= b;
    row_typed   <= typed;
    row_has_res <= has_res;
    row_want    <= want;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // wait for every command, then for bytes that produce none to clear the pipe
  task automatic settle();
    while (pending_cmds.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // queue one message: mostly well-formed channel messages with running status,
  // then system messages, truncated messages and raw noise
  task automatic build_message();
    int         pick;
    int         reps;
    logic [3:0] ch;
    logic [7:0] st;
    logic [6:0] d0;
    logic [6:0] d1;
    pick = $urandom_range(99);
    ch   = ($urandom_range(99) < 80) ? cf_channel : 4'($urandom);
    case ($urandom_range(9))
      0, 1, 2: st = ST_NOTE_ON;
      3:       st = ST_NOTE_OFF;
      4, 5, 6: st = ST_CTRL_CHG;
      7:       st = ST_PROG_CHG;
      default: st = {4'($urandom_range(10, 14)), 4'h0};
    endcase
    if (pick < 62) begin
      byte_burst.push_back(st | {4'h0, ch});
      reps = $urandom_range(1, 3);
      repeat (reps) begin
        if (st == ST_CTRL_CHG) begin
          // small controller pool so values get revisited, both bound halves hit
          d0 = ($urandom_range(3) == 0) ? 7'($urandom)
                                        : {2'($urandom), 2'b00, 3'($urandom)};
          case ($urandom_range(3))
            0:       d1 = 7'h00;
            1:       d1 = 7'h7F;
            2:       d1 = 7'($urandom_range(3));
            default: d1 = 7'($urandom);
          endcase
        end else begin
          d0 = 7'($urandom);
          d1 = ($urandom_range(3) == 0) ? 7'h00 : 7'($urandom);
        end
        byte_burst.push_back({1'b0, d0});
        // stray real-time byte inside a message
        if ($urandom_range(19) == 0)
          byte_burst.push_back({ST_SYSTEM_HI, 4'($urandom_range(8, 15))});
        if (st != ST_PROG_CHG && st != ST_CHAN_PRESS)
          byte_burst.push_back({1'b0, d1});
      end
    end else if (pick < 70) begin
      if ($urandom_range(1) == 0) begin
        byte_burst.push_back(ST_SONG_POS);
        byte_burst.push_back({1'b0, 7'($urandom)});
        byte_burst.push_back({1'b0, 7'($urandom)});
      end else begin
        byte_burst.push_back(ST_SONG_SEL);
        byte_burst.push_back({1'b0, 7'($urandom)});
      end
    end else if (pick < 78) begin
      byte_burst.push_back(ST_SYSEX);
      repeat ($urandom_range(4)) byte_burst.push_back({1'b0, 7'($urandom)});
      byte_burst.push_back(SYSEX_END);
    end else if (pick < 88) begin
      // truncated message
      byte_burst.push_back(st | {4'h0, ch});
      byte_burst.push_back({1'b0, 7'($urandom)});
    end else begin
      repeat ($urandom_range(1, 3)) byte_burst.push_back(8'($urandom));
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // predict on every input transfer, check every output transfer
  always @(posedge clk_i) begin : monitor
    bit          hit;
    cmd_result_t got;
    cmd_result_t want;
    if (in_valid_i && in_ready_o) begin
      parse_midi_byte(midi_byte_i, hit, got);
      if (row_typed) begin
        hit = row_has_res;
        got = row_want;
      end
      if (hit)
        pending_cmds.push_back(got);
    end
    if (out_valid_o && out_ready_i) begin
      if (pending_cmds.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual kind %0d code %h",
                 $time, result_kind_o, command_code_o);
      end else begin
        want = pending_cmds.pop_front();
        check_field("result_kind", 16'(want.kind), 16'(result_kind_o));
        check_field("command_code", want.code, command_code_o);
        check_field("controller_index", 16'(want.ctrl), 16'(controller_index_o));
        check_field("echo_byte", 16'(want.echo), 16'(echo_byte_o));
      end
    end
  end

  // receiver: random stalls, none while steady, and a long hold-off on request
  initial begin : receiver
    int hold_left;
    int holdoff_done;
    hold_left    = 0;
    holdoff_done = 0;
    forever begin
      @(posedge clk_i);
      if (holdoff_asked != holdoff_done) begin
        holdoff_done = holdoff_asked;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= steady || ($urandom_range(99) >= 34);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : stimulus
    int          sent;
    logic [3:0]  ch;
    logic        byp;
    logic [63:0] lo;
    logic [63:0] hi;
    cmd_result_t want;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table at reset configuration
    for (int i = 0; i < DIR_COUNT; i++) begin
      want.kind = DIR_ROWS[i].kind;
      want.code = DIR_ROWS[i].code;
      want.ctrl = '0;
      want.echo = '0;
      send_byte(DIR_ROWS[i].midi, DIR_ROWS[i].typed, DIR_ROWS[i].has_res, want);
    end
    in_valid_i <= 1'b0;
    settle();

    want = '{KIND_NOTE_ON, 16'h0000, 7'h00, 8'h00};
    for (int p = 0; p < PHASES; p++) begin
      // block is idle here: reprogram, junk in the unused upper bits
      ch  = 4'($urandom);
      byp = 1'b0;
      lo  = {$urandom, $urandom};
      hi  = {$urandom, $urandom};
      case (p)
        0: begin
          ch = 4'h0;
          lo = '1;
          hi = '0;
        end
        1: begin
          ch = 4'hF;
          lo = '0;
          hi = '1;
        end
        2: byp = 1'b1;
        4: begin
          lo = '0;
          hi = '0;
        end
        default: begin
        end
      endcase
      write_reg(CFG_LISTEN_CHANNEL, {$urandom, 28'($urandom), ch});
      write_reg(CFG_BYPASS_MODE, {$urandom, 31'($urandom), byp});
      write_reg(CFG_CC_BOUND_LOW, lo);
      write_reg(CFG_CC_BOUND_HIGH, hi);

      // echo phase runs flat out against a long output stall so the input backs up
      steady <= (p == 2) || (p == 4);
      if (p == 2)
        holdoff_asked <= holdoff_asked + 1;

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        build_message();
        while (byte_burst.size() != 0) begin
          send_byte(byte_burst.pop_front(), 1'b0, 1'b0, want);
          sent++;
        end
      end
      in_valid_i <= 1'b0;
      settle();
    end

    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== midi_remote_command_parser_top.f =====
sv/mrcp_pkg.sv
sv/mrcp_front.sv
sv/mrcp_queue.sv
sv/mrcp_ram.sv
sv/mrcp_back.sv
sv/midi_remote_command_parser_top.sv
sim/midi_remote_command_parser_top_test.sv
